/* rtl/stwtr_pkg.sv */
// Shared types and constants for the stack with threshold removal.
package stwtr_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned FILL_W = 5;

	localparam logic signed [DATA_W-1:0] NEG_ONE         = -32'sd1;
	localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 32'sd100;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_REMOVE = 2'd3
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_NOMATCH = 2'd2,
		ST_FULL    = 2'd3
	} status_e_t;

	// Control broadcast from the top level to every cell of the chain.
	typedef struct packed {
		logic  fire;
		op_e_t op;
		logic  found;
	} cell_ctrl_t;

endpackage

/* rtl/stwtr_cell.sv */
// One storage cell of the stack chain with its match and select links.
module stwtr_cell #(
	parameter int unsigned IDX     = 0,
	parameter int unsigned COUNT_W = 5
) (
	input  logic                                     clk,
	input  stwtr_pkg::cell_ctrl_t                    ctrl,
	input  logic [COUNT_W-1:0]                       count,
	input  logic signed [stwtr_pkg::DATA_W-1:0]      push_value,
	input  logic signed [stwtr_pkg::DATA_W-1:0]      threshold,
	input  logic signed [stwtr_pkg::DATA_W-1:0]      value_above,
	input  logic                                     match_above_in,
	input  logic signed [stwtr_pkg::DATA_W-1:0]      sel_in,
	output logic signed [stwtr_pkg::DATA_W-1:0]      value_q,
	output logic                                     match_above_out,
	output logic signed [stwtr_pkg::DATA_W-1:0]      sel_out
);

	logic occupied;
	logic is_top;
	logic is_free;
	logic my_match;
	logic hit;
	logic pick;
	logic shift_en;

	always_comb begin
		occupied = COUNT_W'(IDX) < count;
		is_top   = COUNT_W'(IDX + 1) == count;
		is_free  = COUNT_W'(IDX) == count;
		my_match = occupied && (value_q > threshold);
		// This cell is the topmost match when nothing above it qualifies.
		hit      = my_match && !match_above_in;
		match_above_out = match_above_in || my_match;
		// The matched cell and every occupied cell above it move down by one.
		shift_en = ctrl.found && occupied && !match_above_in;
		if (ctrl.op == stwtr_pkg::OP_REMOVE) begin
			pick = hit;
		end else begin
			pick = is_top;
		end
		sel_out = pick ? value_q : sel_in;
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire && ctrl.op == stwtr_pkg::OP_PUSH && is_free) begin
			value_q <= push_value;
		end else if (ctrl.fire && ctrl.op == stwtr_pkg::OP_REMOVE && shift_en) begin
			value_q <= value_above;
		end
	end

endmodule

/* rtl/stack_with_threshold_removal_core.sv */
// Top level of the bounded LIFO stack with threshold removal.
//
// Usage: requests arrive on the s_ channel, one transfer per request, with the
// operation code in s_tuser and the push value in s_tdata. Every request yields
// exactly one result transfer on the m_ channel: the returned value and the fill
// count in m_tdata, the status code in m_tuser.
// The stack is a row of STACK_DEPTH cells, cell 0 at the bottom. Push writes the
// cell just above the top, pop reads the top, and remove-above finds the topmost
// value greater than the threshold through a match chain that runs down the row,
// then shifts every cell above the match down by one in the same edge.
// The result is registered: it appears in the output register on the edge after
// the request transfer. Throughput is one request per cycle while the receiver
// takes each result; the match and select chains through all cells set the clock
// period. When the receiver stalls, the result waits in the output register and
// s_tready drops until it is taken; a new request is accepted in the very cycle
// the waiting result leaves.
// Reset empties the stack, clears the valid flag of the output register and loads
// the threshold with 100. The user must write the threshold through cfg_we and
// cfg_wdata only while idle; the block itself does not enforce it.
module stack_with_threshold_removal_core #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,     // remove_threshold
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,       // push_value[31:0]
	input  logic [1:0]  s_tuser,       // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,       // result_value[31:0], fill_count[36:32], zeros
	output logic [1:0]  m_tuser        // status[1:0]
);

	localparam int unsigned COUNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned DW      = stwtr_pkg::DATA_W;

	logic signed [DW-1:0]      threshold_q;
	logic [COUNT_W-1:0]        count_q;
	logic [COUNT_W-1:0]        count_next;
	logic                      out_valid_q;
	logic signed [DW-1:0]      out_value_q;
	stwtr_pkg::status_e_t      out_status_q;
	logic [stwtr_pkg::FILL_W-1:0] out_fill_q;

	logic                      fire;
	stwtr_pkg::op_e_t          op;
	stwtr_pkg::cell_ctrl_t     ctrl;
	logic signed [DW-1:0]      res_value;
	stwtr_pkg::status_e_t      res_status;

	// Chain links: index STACK_DEPTH is the open end above the top cell.
	logic signed [DW-1:0] value_link [STACK_DEPTH+1];
	logic                 match_link [STACK_DEPTH+1];
	logic signed [DW-1:0] sel_link   [STACK_DEPTH+1];

	assign s_tready = !out_valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;
	assign op       = stwtr_pkg::op_e_t'(s_tuser);

	assign value_link[STACK_DEPTH] = '0;
	assign match_link[STACK_DEPTH] = 1'b0;
	assign sel_link[STACK_DEPTH]   = '0;

	always_comb begin
		ctrl.fire  = fire;
		ctrl.op    = op;
		// The bottom of the match chain tells whether any stored value qualifies.
		ctrl.found = match_link[0];
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		stwtr_cell #(
			.IDX     (i),
			.COUNT_W (COUNT_W)
		) u_cell (
			.clk             (clk),
			.ctrl            (ctrl),
			.count           (count_q),
			.push_value      (s_tdata),
			.threshold       (threshold_q),
			.value_above     (value_link[i+1]),
			.match_above_in  (match_link[i+1]),
			.sel_in          (sel_link[i+1]),
			.value_q         (value_link[i]),
			.match_above_out (match_link[i]),
			.sel_out         (sel_link[i])
		);
	end

	// Result and next fill count for the request at the input.
	always_comb begin
		res_value  = '0;
		res_status = stwtr_pkg::ST_OK;
		count_next = count_q;
		unique case (op)
			stwtr_pkg::OP_PUSH: begin
				if (count_q == COUNT_W'(STACK_DEPTH)) begin
					res_status = stwtr_pkg::ST_FULL;
				end else begin
					count_next = count_q + 1'b1;
				end
			end
			stwtr_pkg::OP_POP: begin
				if (count_q == '0) begin
					res_value  = stwtr_pkg::NEG_ONE;
					res_status = stwtr_pkg::ST_EMPTY;
				end else begin
					res_value  = sel_link[0];
					count_next = count_q - 1'b1;
				end
			end
			stwtr_pkg::OP_CLEAR: begin
				count_next = '0;
			end
			stwtr_pkg::OP_REMOVE: begin
				if (ctrl.found) begin
					res_value  = sel_link[0];
					count_next = count_q - 1'b1;
				end else begin
					res_value  = stwtr_pkg::NEG_ONE;
					res_status = stwtr_pkg::ST_NOMATCH;
				end
			end
			default: begin
				res_value = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= stwtr_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result payload is loaded only with a request transfer.
	always_ff @(posedge clk) begin
		if (fire) begin
			out_value_q  <= res_value;
			out_status_q <= res_status;
			out_fill_q   <= stwtr_pkg::FILL_W'(count_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_fill_q, out_value_q};
	assign m_tuser  = out_status_q;

	// The fill count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(STACK_DEPTH))
		else $error("fill count above stack depth");

	// Without a request transfer the stack keeps its fill count.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(count_q))
		else $error("fill count changed without a request");

	// A pop from a non-empty stack lowers the count by one.
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op == stwtr_pkg::OP_POP && count_q != '0)
		|=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not lower the fill count");

	// A clear reports success with an empty stack.
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op == stwtr_pkg::OP_CLEAR)
		|=> (m_tvalid && m_tuser == stwtr_pkg::ST_OK && m_tdata[36:32] == '0))
		else $error("clear result is wrong");

endmodule
